// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TGBC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define TGBC_ASSERT(lbl, prop, msg) \
  `TGBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/tgbc_pkg.sv -----
// Package with the shared constants and types of the tile grid box collision block.
package tgbc_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;
  localparam int SNAP_TOL     = 4;

  // Field widths.
  localparam int TS_W      = 7;   // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = 6;
  localparam int PIX_W     = 12;
  localparam int SZ_W      = 9;
  localparam int Y_W       = 13;
  localparam int TV_W      = 5;
  localparam int DIV_W     = 13;  // largest pixel coordinate is 4605
  localparam int FLOOR_W   = DIV_W + TS_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

  localparam logic [TS_W-1:0] TILE_SIZE_RST  = 7'd16;
  localparam logic [TS_W-1:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [TS_W-1:0] MAP_HEIGHT_RST = 7'd64;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_status_t;

endpackage

// ----- rtl/tgbc_div.sv -----
// Iterative restoring divider that turns pixel coordinates into tile indexes.
module tgbc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tgbc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [tgbc_pkg::TS_W-1:0]    divisor_i,
  output tgbc_pkg::div_status_t        status_o
);
  import tgbc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [TS_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [TS_W-1:0]  dvs_q, dvs_d;
  logic [TS_W:0]    trial;
  logic             qbit;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // One quotient bit per cycle, most significant first.
      rem_d = qbit ? TS_W'(trial - {1'b0, dvs_q}) : trial[TS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.done     = done_q;
  assign status_o.quotient = quo_q;

endmodule

// ----- rtl/tgbc_row_mem.sv -----
// Tile flag memory, one row of column flags per word, registered read.
module tgbc_row_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  parameter int AW   = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [COLS-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [COLS-1:0] rdata_o
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tile_grid_box_collision.sv -----
// Query: four 13-bit divisions on the shared divider, then a read of each covered row and a column walk.
// A tile write reads and writes back one memory row and gives no result.
// One item at a time: the input is stalled until the current item is finished.
// After reset a clearing pass writes every row of the map to zero; inputs stall meanwhile.
// Reset is asynchronous, active low; tile_size 16, map_width 64, map_height 64.
module tile_grid_box_collision #(
  parameter int MAX_COLS = tgbc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tgbc_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tgbc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tgbc_pkg::TS_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [tgbc_pkg::COL_W-1:0]       tile_col_i,
  input  logic [tgbc_pkg::COL_W-1:0]       tile_row_i,
  input  logic [tgbc_pkg::TV_W-1:0]        tile_value_i,
  input  logic [tgbc_pkg::PIX_W-1:0]       box_x_i,
  input  logic [tgbc_pkg::PIX_W-1:0]       box_y_i,
  input  logic [tgbc_pkg::SZ_W-1:0]        box_w_i,
  input  logic [tgbc_pkg::SZ_W-1:0]        box_h_i,
  input  logic signed [tgbc_pkg::Y_W-1:0]  current_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_left_o,
  output logic                             hit_right_o,
  output logic                             hit_down_o,
  output logic signed [tgbc_pkg::Y_W-1:0]  snapped_y_o
);
  import tgbc_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW = 23;  // snap test width
  localparam int SW = 22;  // snapped y before saturation

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_WR_RD     = 4'd2;
  localparam logic [3:0] S_WR_WB     = 4'd3;
  localparam logic [3:0] S_DIV_GO    = 4'd4;
  localparam logic [3:0] S_DIV_WAIT  = 4'd5;
  localparam logic [3:0] S_ROWS      = 4'd6;
  localparam logic [3:0] S_DOWN_RD   = 4'd7;
  localparam logic [3:0] S_DOWN_WALK = 4'd8;
  localparam logic [3:0] S_MUL       = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0] state_q, state_d;

  logic [TS_W-1:0] ts_q, mw_q, mh_q;
  logic [TS_W-1:0] ts_eff;

  // Item fields held for the whole transaction.
  logic [8:0]       col_q, row_q;
  logic             val_q;
  logic [PIX_W-1:0] bx_q, by_q;
  logic [SZ_W-1:0]  bw_q, bh_q;
  logic signed [Y_W-1:0] cy_q;

  logic [RW-1:0]    clr_q, clr_d;
  logic [1:0]       sel_q, sel_d;
  logic [DIV_W-1:0] r1_q, cl_q, cr_q;
  logic [DIV_W-1:0] rowc_q, rowc_d, colc_q, colc_d;
  logic             pend_q, pend_d;
  logic             hl_q, hl_d, hr_q, hr_d, any_q, any_d;
  logic [FLOOR_W-1:0] floor_q;

  logic             out_valid_q;
  logic             hl_out_q, hr_out_q, hd_out_q;
  logic signed [Y_W-1:0] sy_out_q;

  logic             accept, load_out;
  logic [DIV_W-1:0] sum_y, sum_x, dividend;
  logic             y_neg, x_neg;
  logic             row_ok, col_ok, lvalid, rvalid, rb_ok;
  div_status_t      div_st;
  logic             div_start;

  logic             mem_we;
  logic [RW-1:0]    mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;

  logic signed [DW-1:0] diff;
  logic signed [SW-1:0] sy_full;
  logic signed [Y_W-1:0] sy_sat;
  logic             hd;

  assign ts_eff = (ts_q == '0) ? TS_W'(1) : ts_q;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // An edge at pixel -1 occurs only for a zero-size box at coordinate zero.
  assign y_neg = (by_q == '0) && (bh_q == '0);
  assign x_neg = (bx_q == '0) && (bw_q == '0);
  assign sum_y = DIV_W'({1'b0, by_q} + {4'b0, bh_q} - DIV_W'(1));
  assign sum_x = DIV_W'({1'b0, bx_q} + {4'b0, bw_q} - DIV_W'(1));

  always_comb begin
    case (sel_q)
      2'd0:    dividend = {1'b0, by_q};
      2'd1:    dividend = sum_y;
      2'd2:    dividend = {1'b0, bx_q};
      default: dividend = sum_x;
    endcase
  end

  assign row_ok = !y_neg && (rowc_q <= r1_q) && (rowc_q < {6'b0, mh_q}) &&
                  (rowc_q < DIV_W'(MAX_ROWS));
  assign col_ok = !x_neg && (colc_q <= cr_q) && (colc_q < {6'b0, mw_q}) &&
                  (colc_q < DIV_W'(MAX_COLS));
  assign lvalid = (cl_q < {6'b0, mw_q}) && (cl_q < DIV_W'(MAX_COLS));
  assign rvalid = !x_neg && (cr_q < {6'b0, mw_q}) && (cr_q < DIV_W'(MAX_COLS));
  assign rb_ok  = !y_neg && (r1_q < {6'b0, mh_q}) && (r1_q < DIV_W'(MAX_ROWS));

  // Snap test and saturated floor position.
  assign diff = $signed({{(DW-Y_W){cy_q[Y_W-1]}}, cy_q}) -
                $signed({{(DW-FLOOR_W){1'b0}}, floor_q}) +
                $signed({{(DW-SZ_W){1'b0}}, bh_q});
  assign hd = any_q && (diff <= $signed(DW'(SNAP_TOL)));
  assign sy_full = $signed({{(SW-FLOOR_W){1'b0}}, floor_q}) -
                   $signed({{(SW-SZ_W){1'b0}}, bh_q});

  always_comb begin
    if (sy_full > $signed(SW'(4095))) begin
      sy_sat = Y_W'(4095);
    end else if (sy_full < -$signed(SW'(4096))) begin
      sy_sat = -$signed(Y_W'(4096));
    end else begin
      sy_sat = sy_full[Y_W-1:0];
    end
  end

  assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    sel_d     = sel_q;
    rowc_d    = rowc_q;
    colc_d    = colc_q;
    pend_d    = pend_q;
    hl_d      = hl_q;
    hr_d      = hr_q;
    any_d     = any_q;
    div_start = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + RW'(1);
        if (clr_q == RW'(MAX_ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          hl_d  = 1'b0;
          hr_d  = 1'b0;
          any_d = 1'b0;
          sel_d = 2'd0;
          if (action_i == ACT_QUERY) begin
            state_d = S_DIV_GO;
          end else if (({3'b0, tile_col_i} < 9'(MAX_COLS)) &&
                       ({3'b0, tile_row_i} < 9'(MAX_ROWS))) begin
            state_d = S_WR_RD;
          end
        end
      end
      S_WR_RD: state_d = S_WR_WB;
      S_WR_WB: state_d = S_IDLE;
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_st.done) begin
          sel_d = sel_q + 2'd1;
          if (sel_q == 2'd0) begin
            rowc_d = div_st.quotient;
          end
          if (sel_q == 2'd2) begin
            colc_d = div_st.quotient;
          end
          if (sel_q == 2'd3) begin
            pend_d  = 1'b0;
            state_d = S_ROWS;
          end else begin
            state_d = S_DIV_GO;
          end
        end
      end
      S_ROWS: begin
        // Read one row per cycle; test the row read in the cycle before.
        if (pend_q) begin
          hl_d = hl_q || (lvalid && mem_rdata[cl_q[CW-1:0]]);
          hr_d = hr_q || (rvalid && mem_rdata[cr_q[CW-1:0]]);
        end
        pend_d = row_ok;
        if (row_ok) begin
          rowc_d = rowc_q + DIV_W'(1);
        end else if (!pend_q) begin
          state_d = rb_ok ? S_DOWN_RD : S_MUL;
        end
      end
      S_DOWN_RD: state_d = S_DOWN_WALK;
      S_DOWN_WALK: begin
        if (col_ok) begin
          if (mem_rdata[colc_q[CW-1:0]]) begin
            any_d   = 1'b1;
            state_d = S_MUL;
          end else begin
            colc_d = colc_q + DIV_W'(1);
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      sel_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ts_q        <= TILE_SIZE_RST;
      mw_q        <= MAP_WIDTH_RST;
      mh_q        <= MAP_HEIGHT_RST;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sel_q   <= sel_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TILE_SIZE:  ts_q <= cfg_data_i;
          CFG_MAP_WIDTH:  mw_q <= cfg_data_i;
          CFG_MAP_HEIGHT: mh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= {3'b0, tile_col_i};
      row_q <= {3'b0, tile_row_i};
      val_q <= (tile_value_i != '0);
      bx_q  <= box_x_i;
      by_q  <= box_y_i;
      bw_q  <= box_w_i;
      bh_q  <= box_h_i;
      cy_q  <= current_y_i;
    end
    if ((state_q == S_DIV_WAIT) && div_st.done) begin
      case (sel_q)
        2'd1:    r1_q <= div_st.quotient;
        2'd2:    cl_q <= div_st.quotient;
        2'd3:    cr_q <= div_st.quotient;
        default: ;
      endcase
    end
    rowc_q <= rowc_d;
    colc_q <= colc_d;
    hl_q   <= hl_d;
    hr_q   <= hr_d;
    any_q  <= any_d;
    if (state_q == S_MUL) begin
      floor_q <= FLOOR_W'(ts_eff) * FLOOR_W'(r1_q);
    end
    if (load_out) begin
      hl_out_q <= hl_q;
      hr_out_q <= hr_q;
      hd_out_q <= hd;
      sy_out_q <= hd ? sy_sat : cy_q;
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q[RW-1:0];
    mem_wdata = mem_rdata;
    mem_wdata[col_q[CW-1:0]] = val_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_WR_WB: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_ROWS:                 mem_raddr = rowc_q[RW-1:0];
      S_DOWN_RD, S_DOWN_WALK: mem_raddr = r1_q[RW-1:0];
      default:                mem_raddr = row_q[RW-1:0];
    endcase
  end

  tgbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ts_eff),
    .status_o   (div_st)
  );

  tgbc_row_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS),
    .AW   (RW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign hit_left_o  = hl_out_q;
  assign hit_right_o = hr_out_q;
  assign hit_down_o  = hd_out_q;
  assign snapped_y_o = sy_out_q;

endmodule

// ----- rtl/tgbc_checker.sv -----
// Port-level checker of the tile grid box collision block, bound to the top level.
`include "assert_macros.svh"

module tgbc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             hit_left_o,
  input logic                             hit_right_o,
  input logic                             hit_down_o,
  input logic signed [tgbc_pkg::Y_W-1:0]  snapped_y_o
);

  // A result that is stalled stays offered.
  `TGBC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `TGBC_ASSERT(a_out_stable, (out_valid_o && out_stall_i) |=> ($stable(hit_left_o) && $stable(hit_right_o) && $stable(hit_down_o) && $stable(snapped_y_o)), "stalled result changed")

  // The block works on one transaction at a time.
  `TGBC_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "input taken while busy")

  // A new result only appears at the end of work on a query.
  `TGBC_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")

endmodule

bind tile_grid_box_collision tgbc_checker u_tgbc_checker (.*);

// ----- tb/sv/tile_grid_box_collision_tb.sv -----
// Self-checking testbench for the tile grid box collision block.
`timescale 1ns / 1ps

module tile_grid_box_collision_tb;
  import tgbc_pkg::*;

  localparam int MAP_COLS      = MAX_COLS_DEF;
  localparam int MAP_ROWS      = MAX_ROWS_DEF;
  localparam int Y_MIN         = -4096;
  localparam int Y_MAX         = 4095;
  localparam int PIX_MAX       = 4095;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic                    action;
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
    logic [TV_W-1:0]         value;
    logic [PIX_W-1:0]        bx;
    logic [PIX_W-1:0]        by;
    logic [SZ_W-1:0]         bw;
    logic [SZ_W-1:0]         bh;
    logic signed [Y_W-1:0]   cy;
  } tile_req_t;

  typedef struct {
    logic                    hit_left;
    logic                    hit_right;
    logic                    hit_down;
    logic signed [Y_W-1:0]   snapped;
  } collision_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [TS_W-1:0]       cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [COL_W-1:0]      tile_col_i;
  logic [COL_W-1:0]      tile_row_i;
  logic [TV_W-1:0]       tile_value_i;
  logic [PIX_W-1:0]      box_x_i;
  logic [PIX_W-1:0]      box_y_i;
  logic [SZ_W-1:0]       box_w_i;
  logic [SZ_W-1:0]       box_h_i;
  logic signed [Y_W-1:0] current_y_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_left_o;
  logic                  hit_right_o;
  logic                  hit_down_o;
  logic signed [Y_W-1:0] snapped_y_o;

  // Shadow copy of the tile map and the configuration registers.
  bit [MAP_COLS-1:0] solid_rows [MAP_ROWS];
  int                cfg_ts;
  int                cfg_map_w;
  int                cfg_map_h;
  int                last_col;
  int                last_row;
  bit                have_solid;

  collision_res_t    expected_q [$];
  collision_res_t    oldest_res;
  int                n_errors = 0;
  int unsigned       cycle_count = 0;
  int unsigned       src_idle_pct = 0;
  int unsigned       sink_stall_pct = 0;
  logic              hold_toggle = 1'b0;
  logic              hold_seen = 1'b0;
  int unsigned       hold_left = 0;

  tile_grid_box_collision i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .tile_col_i   (tile_col_i),
    .tile_row_i   (tile_row_i),
    .tile_value_i (tile_value_i),
    .box_x_i      (box_x_i),
    .box_y_i      (box_y_i),
    .box_w_i      (box_w_i),
    .box_h_i      (box_h_i),
    .current_y_i  (current_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_left_o   (hit_left_o),
    .hit_right_o  (hit_right_o),
    .hit_down_o   (hit_down_o),
    .snapped_y_o  (snapped_y_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off whenever the toggle flips.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no query outstanding");
        n_errors++;
      end else begin
        oldest_res = expected_q.pop_front();
        if (hit_left_o !== oldest_res.hit_left) begin
          $error("hit_left: expected %0b, got %0b", oldest_res.hit_left, hit_left_o);
          n_errors++;
        end
        if (hit_right_o !== oldest_res.hit_right) begin
          $error("hit_right: expected %0b, got %0b", oldest_res.hit_right, hit_right_o);
          n_errors++;
        end
        if (hit_down_o !== oldest_res.hit_down) begin
          $error("hit_down: expected %0b, got %0b", oldest_res.hit_down, hit_down_o);
          n_errors++;
        end
        if (snapped_y_o !== oldest_res.snapped) begin
          $error("snapped_y: expected %0d, got %0d", oldest_res.snapped, snapped_y_o);
          n_errors++;
        end
      end
    end
  end

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int eff_tile_size();
    return (cfg_ts == 0) ? 1 : cfg_ts;
  endfunction

  function automatic int pix_to_tile(input int p);
    if (p < 0) return -1;
    return p / eff_tile_size();
  endfunction

  // Anything off the map, in either the configured or the physical extent, is empty.
  function automatic bit tile_solid_at(input int col, input int row);
    if (col < 0 || row < 0) return 1'b0;
    if (col >= cfg_map_w || col >= MAP_COLS) return 1'b0;
    if (row >= cfg_map_h || row >= MAP_ROWS) return 1'b0;
    return solid_rows[row][col];
  endfunction

  function automatic bit edge_column_hit(input int col, input int r0, input int r1);
    int r;
    for (r = (r0 < 0) ? 0 : r0; r <= min_int(r1, MAP_ROWS - 1); r++)
      if (tile_solid_at(col, r)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic collision_res_t predict_collision(input tile_req_t rq);
    int ts, bx, by, bw, bh, cy, r0, r1, cl, cr, c, sy, floor_y;
    bit below;
    collision_res_t res;
    ts = eff_tile_size();
    bx = int'(rq.bx);
    by = int'(rq.by);
    bw = int'(rq.bw);
    bh = int'(rq.bh);
    cy = int'(rq.cy);
    r0 = pix_to_tile(by);
    r1 = pix_to_tile(by + bh - 1);
    cl = pix_to_tile(bx);
    cr = pix_to_tile(bx + bw - 1);
    res.hit_left  = edge_column_hit(cl, r0, r1);
    res.hit_right = edge_column_hit(cr, r0, r1);
    // The floor row is the one holding the bottom pixel of the box.
    below = 1'b0;
    for (c = (cl < 0) ? 0 : cl; c <= min_int(cr, MAP_COLS - 1); c++)
      if (tile_solid_at(c, r1)) below = 1'b1;
    res.hit_down = 1'b0;
    sy = cy;
    if (below) begin
      floor_y = ts * r1;
      if (cy - floor_y + bh <= SNAP_TOL) begin
        res.hit_down = 1'b1;
        sy = clamp_int(floor_y - bh, Y_MIN, Y_MAX);
      end
    end
    res.snapped = Y_W'(sy);
    return res;
  endfunction

  task automatic track_item(input tile_req_t rq);
    if (rq.action == ACT_WRITE) begin
      solid_rows[rq.row][rq.col] = (rq.value != '0);
      if (rq.value != '0) begin
        last_col   = int'(rq.col);
        last_row   = int'(rq.row);
        have_solid = 1'b1;
      end
    end else begin
      expected_q = {expected_q, predict_collision(rq)};
    end
  endtask

  function automatic tile_req_t make_write(input int col, input int row, input int val);
    tile_req_t rq;
    rq = '{default: '0};
    rq.action = ACT_WRITE;
    rq.col    = COL_W'(col);
    rq.row    = COL_W'(row);
    rq.value  = TV_W'(val);
    return rq;
  endfunction

  function automatic tile_req_t make_query(input int bx, input int by, input int bw,
                                           input int bh, input int cy);
    tile_req_t rq;
    rq = '{default: '0};
    rq.action = ACT_QUERY;
    rq.bx     = PIX_W'(bx);
    rq.by     = PIX_W'(by);
    rq.bw     = SZ_W'(bw);
    rq.bh     = SZ_W'(bh);
    rq.cy     = Y_W'(cy);
    return rq;
  endfunction

  // Mostly writes inside the map and queries aimed at known solid tiles, with
  // current_y placed around the snap threshold; the rest is raw noise.
  function automatic tile_req_t random_item();
    tile_req_t rq;
    int ts, span_c, span_r, col, row, bx, by, bw, bh, cy, bottom;
    ts     = eff_tile_size();
    span_c = min_int(MAP_COLS - 1, cfg_map_w);
    span_r = min_int(MAP_ROWS - 1, cfg_map_h);
    rq.action = 1'($urandom);
    rq.col    = COL_W'($urandom);
    rq.row    = COL_W'($urandom);
    rq.value  = TV_W'($urandom);
    rq.bx     = PIX_W'($urandom);
    rq.by     = PIX_W'($urandom);
    rq.bw     = SZ_W'($urandom);
    rq.bh     = SZ_W'($urandom);
    rq.cy     = Y_W'($urandom);
    if ($urandom_range(99) < 35) begin
      rq.action = ACT_WRITE;
      if ($urandom_range(99) < 85) begin
        rq.col = COL_W'($urandom_range(span_c));
        rq.row = COL_W'($urandom_range(span_r));
      end
      if ($urandom_range(99) < 30) rq.value = '0;
      return rq;
    end
    rq.action = ACT_QUERY;
    if ($urandom_range(99) < 10) return rq;
    bw = $urandom_range(min_int(511, 3 * ts), 1);
    bh = $urandom_range(min_int(511, 3 * ts), 1);
    if ($urandom_range(99) < 5) bw = 0;
    if ($urandom_range(99) < 5) bh = 0;
    if (have_solid && $urandom_range(99) < 60) begin
      col = last_col;
      row = last_row;
    end else begin
      col = $urandom_range(span_c);
      row = $urandom_range(span_r);
    end
    bx = col * ts + $urandom_range(ts - 1);
    if ($urandom_range(1)) bx = bx - (bw - 1);
    by = row * ts + $urandom_range(ts - 1);
    if ($urandom_range(99) < 70) by = by - (bh - 1);
    bx = clamp_int(bx, 0, PIX_MAX);
    by = clamp_int(by, 0, PIX_MAX);
    cy = int'(rq.cy);
    bottom = by + bh - 1;
    if (bottom >= 0 && $urandom_range(99) < 70)
      cy = (bottom / ts) * ts - bh + $urandom_range(12) - 4;
    rq.bx = PIX_W'(bx);
    rq.by = PIX_W'(by);
    rq.bw = SZ_W'(bw);
    rq.bh = SZ_W'(bh);
    rq.cy = Y_W'(clamp_int(cy, Y_MIN, Y_MAX));
    return rq;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and returns at the
  // clock edge where the transaction is accepted.
  task automatic send_item(input tile_req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i     <= rq.action;
    tile_col_i   <= rq.col;
    tile_row_i   <= rq.row;
    tile_value_i <= rq.value;
    box_x_i      <= rq.bx;
    box_y_i      <= rq.by;
    box_w_i      <= rq.bw;
    box_h_i      <= rq.bh;
    current_y_i  <= rq.cy;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    track_item(rq);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // A tile write gives no result, so allow for one still in flight.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= TS_W'(val);
    @(posedge clk_i);
    case (idx)
      CFG_TILE_SIZE:  cfg_ts    = val & 'h7F;
      CFG_MAP_WIDTH:  cfg_map_w = val & 'h7F;
      CFG_MAP_HEIGHT: cfg_map_h = val & 'h7F;
      default: ;
    endcase
  endtask

  task automatic set_config(input int ts, input int mw, input int mh);
    wait_drained();
    write_cfg(CFG_TILE_SIZE, ts);
    write_cfg(CFG_MAP_WIDTH, mw);
    write_cfg(CFG_MAP_HEIGHT, mh);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic_phase(input int ts, input int mw, input int mh, input int n_items,
                                   input int src_pct, input int sink_pct);
    int i;
    set_config(ts, mw, mh);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    for (i = 0; i < n_items; i++) send_item(random_item());
  endtask

  task automatic test_empty_map();
    send_item(make_query(0, 0, 1, 1, 0));
    send_item(make_query(PIX_MAX, PIX_MAX, 511, 511, Y_MAX));
  endtask

  // Tile size 16 here: pixel 80 is column 5, pixel 160 is row 10.
  task automatic test_tile_flags();
    send_item(make_write(0, 0, 31));
    send_item(make_write(63, 63, 1));
    send_item(make_write(5, 10, 1));
    send_item(make_write(6, 10, 16));
    send_item(make_write(6, 10, 0));
    send_item(make_query(80, 160, 16, 16, 148));
    send_item(make_query(80, 160, 16, 16, 149));
    send_item(make_query(50, 160, 40, 16, Y_MIN));
    send_item(make_query(1008, 1008, 16, 16, -1));
    send_item(make_query(0, 0, 256, 256, 0));
    send_item(make_write(63, 63, 0));
    send_item(make_query(1008, 1008, 16, 16, -1));
  endtask

  task automatic test_box_edges();
    send_item(make_query(96, 160, 0, 16, 0));
    send_item(make_query(80, 176, 16, 0, 0));
    send_item(make_query(80, 176, 16, 0, Y_MAX));
    send_item(make_query(0, 0, 0, 0, 0));
    send_item(make_query(PIX_MAX, 0, 1, 1, 0));
  endtask

  task automatic test_config_sweep();
    run_traffic_phase(16, 64, 64, 90, 0, 0);
    run_traffic_phase(1, 16, 16, 90, 65, 0);
    run_traffic_phase(64, 1, 64, 90, 0, 65);
    run_traffic_phase(7, 20, 12, 90, 34, 34);
    run_traffic_phase(0, 127, 1, 90, 0, 0);
    run_traffic_phase(127, 64, 127, 90, 65, 0);
    run_traffic_phase(3, 0, 0, 30, 0, 65);
    run_traffic_phase(32, 127, 127, 80, 34, 34);
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    tile_req_t rq;
    int i;
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    for (i = 0; i < 20; i++) begin
      rq = random_item();
      rq.action = ACT_QUERY;
      send_item(rq);
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_WRITE;
    tile_col_i   <= '0;
    tile_row_i   <= '0;
    tile_value_i <= '0;
    box_x_i      <= '0;
    box_y_i      <= '0;
    box_w_i      <= '0;
    box_h_i      <= '0;
    current_y_i  <= '0;
    foreach (solid_rows[r]) solid_rows[r] = '0;
    cfg_ts     = int'(TILE_SIZE_RST);
    cfg_map_w  = int'(MAP_WIDTH_RST);
    cfg_map_h  = int'(MAP_HEIGHT_RST);
    have_solid = 1'b0;
    last_col   = 0;
    last_row   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The map is cleared after reset before the input opens.
    wait_drained();

    test_empty_map();
    test_tile_flags();
    test_box_edges();
    test_config_sweep();
    test_backpressure();

    wait_drained();
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
